// ===== design/hfcs_pkg.sv =====
// hfcs_pkg: shared constants and helpers for the hold / fade crossfade splitter
// holds field widths, fixed-point formats, register codes and cosine coefficients
// no dependencies
package hfcs_pkg;

    // fixed field widths
    localparam int CHANNELS   = 2;
    localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LEN_BITS   = 24;
    localparam int INDEX_BITS = 25;
    localparam int CFG_IDX_BITS = 1;

    // fixed-point formats
    localparam int P_BITS     = 16;
    localparam int FRAC_BITS  = 24;
    localparam int SQ_SHIFT   = 2 * P_BITS - FRAC_BITS;
    localparam int U_BITS     = 24;
    localparam int POLY_BITS  = 28;
    localparam int POLY_STEPS = 5;
    localparam int STEP_BITS  = 3;

    // register codes
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FADE = 1'b1;

    localparam logic [LEN_BITS-1:0] FADE_RESET = 24'd441;

    typedef logic [POLY_BITS-1:0] poly_t;

    localparam poly_t Q24_ONE = poly_t'(1) << FRAC_BITS;
    localparam poly_t CF1 = 28'd82792242;
    localparam poly_t CF2 = 28'd68093890;
    localparam poly_t CF3 = 28'd22401992;
    localparam poly_t CF4 = 28'd3948193;
    localparam poly_t CF5 = 28'd432968;

    // horner coefficient, innermost first
    function automatic poly_t poly_coef(input logic [STEP_BITS-1:0] k);
        poly_t c;
        case (k)
            3'd0:    c = CF5;
            3'd1:    c = CF4;
            3'd2:    c = CF3;
            3'd3:    c = CF2;
            3'd4:    c = CF1;
            default: c = CF1;
        endcase
        return c;
    endfunction

endpackage

// ===== design/hfcs_div.sv =====
// hfcs_div: bit-serial restoring divider, one quotient bit per cycle
// gives floor(num * 2^P_BITS / den) for num < den; uses hfcs_pkg
module hfcs_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [hfcs_pkg::LEN_BITS-1:0]    num,
    input  logic [hfcs_pkg::LEN_BITS-1:0]    den,
    output logic                             done,
    output logic [hfcs_pkg::P_BITS-1:0]      quot
);

    localparam int CW = $clog2(hfcs_pkg::P_BITS + 1);

    logic [hfcs_pkg::LEN_BITS-1:0] rem_reg;
    logic [hfcs_pkg::LEN_BITS-1:0] den_reg;
    logic [hfcs_pkg::P_BITS-1:0]   quot_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          done_reg;

    logic [hfcs_pkg::LEN_BITS:0]   shifted;
    logic                          ge;
    logic [hfcs_pkg::LEN_BITS:0]   diff;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        ge      = (shifted >= {1'b0, den_reg});
        diff    = shifted - {1'b0, den_reg};
    end

    // quotient shift register and remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            // done pulses after the last quotient bit
            done_reg <= !start && (cnt_reg == CW'(1));
            if (start)
            begin
                rem_reg  <= num;
                den_reg  <= den;
                quot_reg <= '0;
                cnt_reg  <= CW'(hfcs_pkg::P_BITS);
            end
            else if (cnt_reg != '0)
            begin
                rem_reg  <= ge ? diff[hfcs_pkg::LEN_BITS-1:0]
                               : shifted[hfcs_pkg::LEN_BITS-1:0];
                quot_reg <= {quot_reg[hfcs_pkg::P_BITS-2:0], ge};
                cnt_reg  <= cnt_reg - CW'(1);
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== design/hfcs_mul.sv =====
// hfcs_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// signed multiplicand times unsigned multiplier; no package dependency
module hfcs_mul
#(
    parameter int AW = 28,
    parameter int BW = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [AW-1:0]     a,
    input  logic [BW-1:0]            b,
    output logic                     done,
    output logic signed [AW+BW-1:0]  prod
);

    localparam int CW = $clog2(BW + 1);

    logic signed [AW-1:0] a_reg;
    logic signed [AW:0]   hi_reg;
    logic [BW-1:0]        lo_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 done_reg;

    logic signed [AW:0]   sum;

    // partial product for the current multiplier bit
    always_comb
    begin
        sum = hi_reg + (lo_reg[0] ? {a_reg[AW-1], a_reg} : '0);
    end

    // accumulator shifts right, product bits fill in from the top of lo
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            // done pulses after the last multiplier bit
            done_reg <= !start && (cnt_reg == CW'(1));
            if (start)
            begin
                a_reg   <= a;
                hi_reg  <= '0;
                lo_reg  <= b;
                cnt_reg <= CW'(BW);
            end
            else if (cnt_reg != '0)
            begin
                hi_reg  <= {sum[AW], sum[AW:1]};
                lo_reg  <= {sum[0], lo_reg[BW-1:1]};
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg[AW-1:0], lo_reg};

endmodule

// ===== design/hold_fade_crossfade_splitter_unit.sv =====
// hold_fade_crossfade_splitter_unit: splits stereo frames into transient and tonal parts
// top level sequencer; uses hfcs_pkg, hfcs_div and hfcs_mul
//
// - input channel: in_valid / in_stall carry one frame per transaction
//   (start_req, left_sample, right_sample); start_req restarts the frame index at zero
// - output channel: out_valid / out_stall carry one result per frame
//   (trans_left, trans_right, tonal_left, tonal_right); trans + tonal equals the input
// - configuration: cfg_we writes cfg_data to hold_length or fade_length by cfg_index;
//   the user must write only while the block is idle; the block does not enforce this
// - hold and tail frames take two bit-serial multiplier passes, one per channel;
//   fade frames first add a division and the bit-serial polynomial passes
// - one frame at a time: in_stall is high from acceptance until the result moves
//   into the output register, so no new frame is taken while one is in work
// - a finished result waits in the output register while out_stall is high; the
//   next frame is accepted meanwhile and holds in its last state until the
//   output register frees
// - reset clears the frame index, hold_length to 0 and fade_length to 441
module hold_fade_crossfade_splitter_unit
#(
    parameter int SAMPLE_BITS = 24,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [hfcs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [hfcs_pkg::LEN_BITS-1:0]         cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  start_req,
    input  logic signed [SAMPLE_BITS-1:0]         left_sample,
    input  logic signed [SAMPLE_BITS-1:0]         right_sample,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]         trans_left,
    output logic signed [SAMPLE_BITS-1:0]         trans_right,
    output logic signed [SAMPLE_BITS-1:0]         tonal_left,
    output logic signed [SAMPLE_BITS-1:0]         tonal_right
);

    localparam int AW = (SAMPLE_BITS > hfcs_pkg::POLY_BITS) ? SAMPLE_BITS
                                                           : hfcs_pkg::POLY_BITS;
    localparam int BW = (WEIGHT_BITS + 1 > hfcs_pkg::U_BITS) ? WEIGHT_BITS + 1
                                                            : hfcs_pkg::U_BITS;
    localparam int PW = AW + BW;
    localparam int LB = hfcs_pkg::LEN_BITS;
    localparam int IB = hfcs_pkg::INDEX_BITS;
    localparam int PB = hfcs_pkg::P_BITS;
    localparam int FB = hfcs_pkg::FRAC_BITS;
    localparam int CB = hfcs_pkg::CH_BITS;

    localparam logic [WEIGHT_BITS:0] W_FULL = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;
    localparam logic [IB-1:0]        IDX_MAX = '1;
    localparam logic [PB:0]          P_HALF = (PB + 1)'(1) << (PB - 1);
    localparam logic [PB:0]          P_ONE  = (PB + 1)'(1) << PB;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_POLY,
        S_LAUNCH,
        S_MUL,
        S_FIN
    } state_t;

    state_t                         state_reg;

    // configuration and frame position
    logic [LB-1:0]                  hold_reg;
    logic [LB-1:0]                  fade_reg;
    logic [IB-1:0]                  frame_index_reg;

    // per-frame work registers
    logic signed [SAMPLE_BITS-1:0]  samp_reg  [hfcs_pkg::CHANNELS];
    logic signed [SAMPLE_BITS-1:0]  trans_reg [hfcs_pkg::CHANNELS];
    logic signed [SAMPLE_BITS-1:0]  tonal_reg [hfcs_pkg::CHANNELS];
    logic [LB-1:0]                  offset_reg;
    logic [LB-1:0]                  den_reg;
    logic                           p_low_reg;
    logic [hfcs_pkg::U_BITS-1:0]    u_reg;
    logic [WEIGHT_BITS:0]           w_reg;
    logic [hfcs_pkg::STEP_BITS-1:0] step_reg;
    logic [CB-1:0]                  ch_reg;

    // shared unit controls
    logic                           div_start_reg;
    logic                           mul_start_reg;
    logic signed [AW-1:0]           mul_a_reg;
    logic [BW-1:0]                  mul_b_reg;

    // output register
    logic                           out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  trans_o_reg [hfcs_pkg::CHANNELS];
    logic signed [SAMPLE_BITS-1:0]  tonal_o_reg [hfcs_pkg::CHANNELS];

    // unit results
    logic                           div_done;
    logic [PB-1:0]                  div_quot;
    logic                           mul_done;
    logic signed [PW-1:0]           mul_prod;

    // combinational helpers
    logic                           accept;
    logic [IB-1:0]                  idx;
    logic [LB-1:0]                  fade_eff;
    logic                           in_hold;
    logic [IB-1:0]                  offset;
    logic                           in_fade;
    logic [IB-1:0]                  index_next;
    logic                           p_low;
    logic [PB:0]                    x_next;
    logic [hfcs_pkg::U_BITS-1:0]    u_next;
    hfcs_pkg::poly_t                t_prod;
    hfcs_pkg::poly_t                r_next;
    logic [FB:0]                    c_cos;
    logic [FB+1:0]                  w24_sum;
    logic [FB:0]                    w24;
    logic [FB+WEIGHT_BITS+1:0]      w_scaled;
    logic [WEIGHT_BITS:0]           w_next;
    logic signed [PW-1:0]           rounded;
    logic signed [SAMPLE_BITS-1:0]  trans_next;
    logic                           out_free;
    logic                           div_launch;
    logic                           mul_launch;
    logic                           out_load;

    hfcs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (offset_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    hfcs_mul
    #(
        .AW (AW),
        .BW (BW)
    )
    u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // frame position and region decode
    always_comb
    begin
        accept     = in_valid && (state_reg == S_IDLE);
        idx        = start_req ? '0 : frame_index_reg;
        fade_eff   = (fade_reg == '0) ? LB'(1) : fade_reg;
        in_hold    = (idx < {1'b0, hold_reg});
        offset     = idx - {1'b0, hold_reg};
        in_fade    = !in_hold && (offset < {1'b0, fade_eff});
        index_next = (idx == IDX_MAX) ? IDX_MAX : idx + IB'(1);
    end

    // phase fold, polynomial steps and weight
    always_comb
    begin
        p_low    = ({1'b0, div_quot} <= P_HALF);
        x_next   = p_low ? {1'b0, div_quot} : P_ONE - {1'b0, div_quot};
        u_next   = mul_prod[hfcs_pkg::SQ_SHIFT +: hfcs_pkg::U_BITS];
        t_prod   = mul_prod[FB +: hfcs_pkg::POLY_BITS];
        r_next   = hfcs_pkg::poly_coef(step_reg) - t_prod;
        c_cos    = (t_prod >= hfcs_pkg::Q24_ONE) ? '0
                 : (FB + 1)'(hfcs_pkg::Q24_ONE - t_prod);
        w24_sum  = p_low_reg ? (FB + 2)'(hfcs_pkg::Q24_ONE) + {1'b0, c_cos}
                             : (FB + 2)'(hfcs_pkg::Q24_ONE) - {1'b0, c_cos};
        w24      = w24_sum[FB+1:1];
        w_scaled = {1'b0, w24, {WEIGHT_BITS{1'b0}}}
                 + (FB + WEIGHT_BITS + 2)'(1 << (FB - 1));
        w_next   = w_scaled[FB +: WEIGHT_BITS + 1];
    end

    // rounded transient part of the current channel
    always_comb
    begin
        rounded    = mul_prod + PW'(1 << (WEIGHT_BITS - 1));
        trans_next = rounded[WEIGHT_BITS +: SAMPLE_BITS];
        out_free   = !out_valid_reg || !out_stall;
    end

    // unit launches and output register load
    always_comb
    begin
        div_launch = accept && in_fade;
        mul_launch = ((state_reg == S_DIV) && div_done)
                  || ((state_reg == S_POLY) && mul_done
                      && (step_reg != hfcs_pkg::STEP_BITS'(hfcs_pkg::POLY_STEPS)))
                  || (state_reg == S_LAUNCH);
        out_load   = (state_reg == S_FIN) && out_free;
    end

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            hold_reg        <= '0;
            fade_reg        <= hfcs_pkg::FADE_RESET;
            frame_index_reg <= '0;
            div_start_reg   <= 1'b0;
            mul_start_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            div_start_reg <= div_launch;
            mul_start_reg <= mul_launch;

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    hfcs_pkg::REG_HOLD: hold_reg <= cfg_data;
                    hfcs_pkg::REG_FADE: fade_reg <= cfg_data;
                    default:            ;
                endcase
            end

            // output handshake
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        samp_reg[0]     <= left_sample;
                        samp_reg[1]     <= right_sample;
                        frame_index_reg <= index_next;
                        offset_reg      <= offset[LB-1:0];
                        den_reg         <= fade_eff;
                        ch_reg          <= '0;
                        if (in_hold)
                        begin
                            w_reg     <= W_FULL;
                            state_reg <= S_LAUNCH;
                        end
                        else if (in_fade)
                        begin
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            w_reg     <= '0;
                            state_reg <= S_LAUNCH;
                        end
                    end
                end

                S_DIV:
                begin
                    // square the folded phase first
                    if (div_done)
                    begin
                        p_low_reg     <= p_low;
                        mul_a_reg     <= AW'(x_next);
                        mul_b_reg     <= BW'(x_next);
                        step_reg      <= '0;
                        state_reg     <= S_POLY;
                    end
                end

                S_POLY:
                begin
                    if (mul_done)
                    begin
                        if (step_reg == '0)
                        begin
                            u_reg         <= u_next;
                            mul_a_reg     <= AW'(hfcs_pkg::poly_coef(step_reg));
                            mul_b_reg     <= BW'(u_next);
                            step_reg      <= step_reg + hfcs_pkg::STEP_BITS'(1);
                        end
                        else if (step_reg != hfcs_pkg::STEP_BITS'(hfcs_pkg::POLY_STEPS))
                        begin
                            mul_a_reg     <= AW'(r_next);
                            mul_b_reg     <= BW'(u_reg);
                            step_reg      <= step_reg + hfcs_pkg::STEP_BITS'(1);
                        end
                        else
                        begin
                            w_reg     <= w_next;
                            state_reg <= S_LAUNCH;
                        end
                    end
                end

                S_LAUNCH:
                begin
                    mul_a_reg     <= AW'(samp_reg[ch_reg]);
                    mul_b_reg     <= BW'(w_reg);
                    state_reg     <= S_MUL;
                end

                S_MUL:
                begin
                    if (mul_done)
                    begin
                        trans_reg[ch_reg] <= trans_next;
                        tonal_reg[ch_reg] <= samp_reg[ch_reg] - trans_next;
                        if (ch_reg == CB'(hfcs_pkg::CHANNELS - 1))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + CB'(1);
                            state_reg <= S_LAUNCH;
                        end
                    end
                end

                S_FIN:
                begin
                    // wait for the output register to free
                    if (out_free)
                    begin
                        trans_o_reg   <= trans_reg;
                        tonal_o_reg   <= tonal_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign trans_left  = trans_o_reg[0];
    assign trans_right = trans_o_reg[1];
    assign tonal_left  = tonal_o_reg[0];
    assign tonal_right = tonal_o_reg[1];

endmodule

// ===== design/hfcs_checker.sv =====
// hfcs_checker: port-level assertions for the crossfade splitter
// bound to hold_fade_crossfade_splitter_unit; no package dependency
module hfcs_checker
#(
    parameter int SAMPLE_BITS = 24
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] trans_left,
    input logic signed [SAMPLE_BITS-1:0] trans_right,
    input logic signed [SAMPLE_BITS-1:0] tonal_left,
    input logic signed [SAMPLE_BITS-1:0] tonal_right
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(trans_left)
            && $stable(trans_right) && $stable(tonal_left) && $stable(tonal_right))
    else $error("stalled result changed");

    // one frame at a time: an accepted transaction closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken while a frame is in work");

    // a new result only comes out of a frame in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result without a frame in work");

    // a result taken is followed only by a result from a frame in work
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid || $past(in_stall))
    else $error("result repeated");

endmodule

bind hold_fade_crossfade_splitter_unit hfcs_checker
#(
    .SAMPLE_BITS (SAMPLE_BITS)
)
u_hfcs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .trans_left  (trans_left),
    .trans_right (trans_right),
    .tonal_left  (tonal_left),
    .tonal_right (tonal_right)
);

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for hold_fade_crossfade_splitter_unit
// predicts every transient / tonal split in-bench and checks each result transaction
// depends on hfcs_pkg and hold_fade_crossfade_splitter_unit
module tb_top;

    localparam int SB = 24;
    localparam int WB = 16;
    localparam longint unsigned Q24_UNITY = 64'd1 << 24;
    localparam longint unsigned INDEX_CAP = (64'd1 << 25) - 1;
    localparam longint unsigned TAYLOR_C1 = 64'd82792242;
    localparam longint unsigned TAYLOR_C2 = 64'd68093890;
    localparam longint unsigned TAYLOR_C3 = 64'd22401992;
    localparam longint unsigned TAYLOR_C4 = 64'd3948193;
    localparam longint unsigned TAYLOR_C5 = 64'd432968;
    localparam logic signed [SB-1:0] SAMPLE_MAX = 24'sh7fffff;
    localparam logic signed [SB-1:0] SAMPLE_MIN = 24'sh800000;

    typedef struct {
        logic signed [SB-1:0] trans_l;
        logic signed [SB-1:0] trans_r;
        logic signed [SB-1:0] tonal_l;
        logic signed [SB-1:0] tonal_r;
    } split_t;

    // clock, reset and block inputs
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [hfcs_pkg::CFG_IDX_BITS-1:0] cfg_index = hfcs_pkg::REG_HOLD;
    logic [hfcs_pkg::LEN_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic start_req = 1'b0;
    logic signed [SB-1:0] left_sample = '0;
    logic signed [SB-1:0] right_sample = '0;
    logic out_stall = 1'b0;

    logic in_stall;
    logic out_valid;
    logic signed [SB-1:0] trans_left;
    logic signed [SB-1:0] trans_right;
    logic signed [SB-1:0] tonal_left;
    logic signed [SB-1:0] tonal_right;

    // bench copy of the block state
    longint unsigned hold_len = 0;
    longint unsigned fade_len = 441;
    longint unsigned next_index = 0;

    split_t pending_splits[$];
    int mismatch_count = 0;
    bit no_idle = 1'b0;
    logic rx_hold = 1'b0;
    int rx_wait = 0;

    always #10 clk = ~clk;

    hold_fade_crossfade_splitter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_req    (start_req),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .trans_left   (trans_left),
        .trans_right  (trans_right),
        .tonal_left   (tonal_left),
        .tonal_right  (tonal_right)
    );

    // cos(pi x) in Q0.24 from a Q0.16 phase, Horner form, truncating products
    function automatic longint unsigned cos_pi_q24(longint unsigned x);
        longint unsigned u;
        longint unsigned acc;
        longint unsigned t;
        u = (x * x) >> 8;
        acc = TAYLOR_C5;
        acc = TAYLOR_C4 - ((acc * u) >> 24);
        acc = TAYLOR_C3 - ((acc * u) >> 24);
        acc = TAYLOR_C2 - ((acc * u) >> 24);
        acc = TAYLOR_C1 - ((acc * u) >> 24);
        t = (acc * u) >> 24;
        return (t >= Q24_UNITY) ? 64'd0 : Q24_UNITY - t;
    endfunction

    // cos-squared transient weight, Q0.16 with unity at 2^16
    function automatic longint unsigned crossfade_weight(longint unsigned phase);
        longint unsigned w24;
        if (phase <= 64'd32768)
            w24 = (Q24_UNITY + cos_pi_q24(phase)) >> 1;
        else
            w24 = (Q24_UNITY - cos_pi_q24(64'd65536 - phase)) >> 1;
        return ((w24 << WB) + (64'd1 << 23)) >> 24;
    endfunction

    // rounded sample times weight
    function automatic longint transient_of(longint s, longint unsigned w);
        longint prod;
        prod = s * $signed(w) + 64'sd32768;
        return prod >>> WB;
    endfunction

    // expected split for one frame; advances the frame index
    function automatic split_t predict_split(logic st, logic signed [SB-1:0] l,
                                             logic signed [SB-1:0] r);
        longint unsigned fade;
        longint unsigned idx;
        longint unsigned w;
        longint s_l;
        longint s_r;
        longint t_l;
        longint t_r;
        split_t res;
        fade = (fade_len == 0) ? 64'd1 : fade_len;
        idx = st ? 64'd0 : next_index;
        if (idx < hold_len)
            w = 64'd1 << WB;
        else if (idx - hold_len < fade)
            w = crossfade_weight(((idx - hold_len) << 16) / fade);
        else
            w = 0;
        s_l = l;
        s_r = r;
        t_l = transient_of(s_l, w);
        t_r = transient_of(s_r, w);
        res.trans_l = SB'(t_l);
        res.trans_r = SB'(t_r);
        res.tonal_l = SB'(s_l - t_l);
        res.tonal_r = SB'(s_r - t_r);
        next_index = (idx < INDEX_CAP) ? idx + 1 : INDEX_CAP;
        return res;
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SB'($urandom_range(0, 31)) - 24'd16;
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [hfcs_pkg::LEN_BITS-1:0] rand_length();
        case ($urandom_range(0, 19))
            0: return 24'hffffff;
            1: return hfcs_pkg::LEN_BITS'($urandom);
            2: return 24'd0;
            default: return hfcs_pkg::LEN_BITS'($urandom_range(1, 60));
        endcase
    endfunction

    // offer one frame and wait for the transaction
    task automatic send_frame(input logic st, input logic signed [SB-1:0] l,
                              input logic signed [SB-1:0] r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_req <= st;
        left_sample <= l;
        right_sample <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_splits.push_back(predict_split(st, l, r));
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_splits.size() != 0)
            @(posedge clk);
    endtask

    // write both length registers while the block is idle
    task automatic configure(input logic [hfcs_pkg::LEN_BITS-1:0] hold,
                             input logic [hfcs_pkg::LEN_BITS-1:0] fade);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= hfcs_pkg::REG_HOLD;
        cfg_data <= hold;
        @(posedge clk);
        cfg_index <= hfcs_pkg::REG_FADE;
        cfg_data <= fade;
        @(posedge clk);
        cfg_we <= 1'b0;
        hold_len = hold;
        fade_len = fade;
    endtask

    // receiver: random stall before each result, plus the long hold-off
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            rx_wait = no_idle ? 0 : $urandom_range(0, 11);
        if (rx_hold || rx_wait > 0)
        begin
            out_stall <= 1'b1;
            if (rx_wait > 0)
                rx_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        split_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_splits.size() == 0)
            begin
                $error("result with no frame outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_splits.pop_front();
                if (trans_left !== want.trans_l)
                begin
                    $error("trans_left: expected %0d, got %0d", want.trans_l, trans_left);
                    mismatch_count++;
                end
                if (trans_right !== want.trans_r)
                begin
                    $error("trans_right: expected %0d, got %0d", want.trans_r, trans_right);
                    mismatch_count++;
                end
                if (tonal_left !== want.tonal_l)
                begin
                    $error("tonal_left: expected %0d, got %0d", want.tonal_l, tonal_left);
                    mismatch_count++;
                end
                if (tonal_right !== want.tonal_r)
                begin
                    $error("tonal_right: expected %0d, got %0d", want.tonal_r, tonal_right);
                    mismatch_count++;
                end
            end
        end
    end

    // reset values: no hold, 441-frame fade
    task automatic test_default_registers();
        send_frame(1'b1, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
        send_frame(1'b0, 24'sd0, -24'sd1);
    endtask

    // hold, quarter points of the fade including the midpoint, then tail
    task automatic test_fade_shape();
        configure(24'd2, 24'd4);
        send_frame(1'b1, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, SAMPLE_MIN, 24'sd1);
        for (int k = 0; k < 6; k++)
            send_frame(1'b0, (k % 2) ? SAMPLE_MIN : SAMPLE_MAX, rand_sample());
    endtask

    // zero fade length acts as a one-frame fade
    task automatic test_zero_fade();
        configure(24'd1, 24'd0);
        send_frame(1'b1, SAMPLE_MAX, SAMPLE_MIN);
        for (int k = 0; k < 3; k++)
            send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
    endtask

    // largest hold, then largest fade
    task automatic test_length_extremes();
        configure(24'hffffff, 24'hffffff);
        send_frame(1'b1, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
        configure(24'd0, 24'hffffff);
        send_frame(1'b1, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
    endtask

    // new lengths take effect mid-buffer without restarting the index
    task automatic test_write_mid_buffer();
        configure(24'd0, 24'd8);
        send_frame(1'b1, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, rand_sample(), rand_sample());
        configure(24'd2, 24'd12);
        for (int k = 0; k < 3; k++)
            send_frame(1'b0, rand_sample(), rand_sample());
    endtask

    // receiver holds off for a long stretch while frames keep coming
    task automatic test_receiver_hold();
        configure(24'd2, 24'd6);
        no_idle = 1'b1;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (800) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int k = 0; k < 12; k++)
            send_frame(k == 0, rand_sample(), rand_sample());
        wait_drained();
        no_idle = 1'b0;
    endtask

    // sender pauses mid-buffer until everything has come back
    task automatic test_sender_pause();
        configure(24'd4, 24'd20);
        for (int k = 0; k < 10; k++)
            send_frame(k == 0, rand_sample(), rand_sample());
        wait_drained();
        for (int k = 0; k < 10; k++)
            send_frame(1'b0, rand_sample(), rand_sample());
    endtask

    // random buffers under changing lengths, with stray restarts
    task automatic test_random_buffers(input int n_items);
        int sent;
        int span;
        int buf_len;
        logic st;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
                configure(($urandom_range(0, 3) == 0) ? 24'd0 : rand_length(), rand_length());
            no_idle = ($urandom_range(0, 7) == 0);
            span = (hold_len + fade_len + 8 > 160) ? 160 : int'(hold_len + fade_len + 8);
            buf_len = $urandom_range(1, span);
            for (int k = 0; k < buf_len; k++)
            begin
                if (k == 0)
                    st = ($urandom_range(0, 7) != 0);
                else
                    st = ($urandom_range(0, 39) == 0);
                send_frame(st, rand_sample(), rand_sample());
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_default_registers();
        test_fade_shape();
        test_zero_fade();
        test_length_extremes();
        test_write_mid_buffer();
        test_receiver_hold();
        test_sender_pause();
        test_random_buffers(2000);
        wait_drained();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
